// ===== hw/rtl/mqrm_pkg.sv =====
// Shared operation codes, status codes and fixed field widths of the queue manager.
package mqrm_pkg;

	localparam int OP_W     = 3;
	localparam int QID_W    = 3;
	localparam int VAL_W    = 32;
	localparam int STATUS_W = 2;

	localparam logic [OP_W-1:0] OP_ALLOC  = 3'd0;
	localparam logic [OP_W-1:0] OP_FREE   = 3'd1;
	localparam logic [OP_W-1:0] OP_INSERT = 3'd2;
	localparam logic [OP_W-1:0] OP_POP    = 3'd3;
	localparam logic [OP_W-1:0] OP_QUERY  = 3'd4;

	localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NOFREE = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL   = 2'd2;
	localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd3;

endpackage

// ===== hw/rtl/mqrm_ptr_table.sv =====
// Per-queue pointer memory (head, tail, count) with reset valid bits per entry.
module mqrm_ptr_table #(
	parameter int NUM_QUEUES = 8,
	parameter int AW         = 3,
	parameter int DW         = 25
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [DW-1:0] rd_data,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [DW-1:0] wr_data
);

	logic [DW-1:0]         mem [NUM_QUEUES];
	logic [NUM_QUEUES-1:0] vld_q;
	logic [DW-1:0]         rd_s1;
	logic                  rd_vld_s1;

	// mark an entry valid on its first write; never-written entries read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q     <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			if (wr_en)
				vld_q[wr_addr] <= 1'b1;
			if (rd_en)
				rd_vld_s1 <= vld_q[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
		if (rd_en)
			rd_s1 <= mem[rd_addr];
	end

	assign rd_data = rd_vld_s1 ? rd_s1 : '0;

endmodule

// ===== hw/rtl/multi_queue_ring_manager_unit.sv =====
// Top level: bank of circular FIFO queues sharing one element store.
//
//  channel  | handshake          | fields
//  ---------+--------------------+----------------------------------------------
//  request  | start & !busy      | op, queue_id, element_value
//  result   | done (one cycle)   | status, popped_value, granted_queue, is_empty
//
// Flow: a request passes the pointer memory read, then the read-modify-write
// decision, then the result registers; a successful pop adds the element store
// read between the decision and the result registers. busy rises after the
// request is accepted and is low again in the strobe cycle, so a new request may be
// accepted in the same cycle that done is high. Reset clears the in-use flags
// and the pointer valid bits at once; the element store is not cleared. The
// receiver cannot stall: each result shows for one cycle.
module multi_queue_ring_manager_unit #(
	parameter int NUM_QUEUES  = 8,
	parameter int QUEUE_DEPTH = 256,
	parameter int ELEM_WIDTH  = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [mqrm_pkg::OP_W-1:0]     op,
	input  logic [mqrm_pkg::QID_W-1:0]    queue_id,
	input  logic [mqrm_pkg::VAL_W-1:0]    element_value,
	output logic                          done,
	output logic [mqrm_pkg::STATUS_W-1:0] status,
	output logic [mqrm_pkg::VAL_W-1:0]    popped_value,
	output logic [mqrm_pkg::QID_W-1:0]    granted_queue,
	output logic                          is_empty
);

	import mqrm_pkg::*;

	localparam int QW  = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
	localparam int PW  = $clog2(QUEUE_DEPTH);
	localparam int CW  = $clog2(QUEUE_DEPTH + 1);
	localparam int AW  = $clog2(NUM_QUEUES * QUEUE_DEPTH);
	localparam int DW  = 2 * PW + CW;
	localparam int XW  = (ELEM_WIDTH > VAL_W) ? ELEM_WIDTH : VAL_W;
	localparam int SD  = NUM_QUEUES * QUEUE_DEPTH;

	localparam logic [6:0]    NQ_LIM   = 7'(NUM_QUEUES);
	localparam logic [PW-1:0] PTR_LAST = PW'(QUEUE_DEPTH - 1);
	localparam logic [CW-1:0] CNT_FULL = CW'(QUEUE_DEPTH);
	localparam logic [AW-1:0] DEPTH_A  = AW'(QUEUE_DEPTH);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_PTR  = 2'd1;
	localparam logic [1:0] S_POP  = 2'd2;

	logic [1:0] state_q, state_d;

	// latched request
	logic [OP_W-1:0]       op_q;
	logic [QW-1:0]         qid_q;
	logic                  qv_q;
	logic [ELEM_WIDTH-1:0] val_q;
	logic [QW-1:0]         grant_q;
	logic                  found_q;
	logic                  pend_empty_q;

	logic [NUM_QUEUES-1:0] in_use_q;

	// lowest free queue
	logic [QW-1:0] grant_c;
	logic          found_c;

	// pointer memory
	logic          pt_re;
	logic [DW-1:0] pt_rdata, pt_wdata;
	logic          pt_we;
	logic [QW-1:0] pt_waddr;
	logic [PW-1:0] head_c, tail_c;
	logic [CW-1:0] cnt_c;

	// element store
	logic [ELEM_WIDTH-1:0] store_mem [SD];
	logic [ELEM_WIDTH-1:0] store_rd_s1;
	logic                  st_we, st_re;
	logic [AW-1:0]         st_addr;
	logic [XW-1:0]         val_ext, pop_ext;

	// result decision
	logic                res_fire;
	logic [STATUS_W-1:0] res_status;
	logic [VAL_W-1:0]    res_popped;
	logic [QID_W-1:0]    res_granted;
	logic                res_empty;
	logic                use_set, use_clr;

	always_comb begin
		grant_c = '0;
		found_c = 1'b0;
		for (int i = NUM_QUEUES - 1; i >= 0; i--) begin
			if (!in_use_q[i]) begin
				grant_c = QW'(i);
				found_c = 1'b1;
			end
		end
	end

	assign busy    = (state_q != S_IDLE);
	assign pt_re   = (state_q == S_IDLE) && start;
	assign val_ext = XW'(element_value);
	assign pop_ext = XW'(store_rd_s1);

	assign {head_c, tail_c, cnt_c} = pt_rdata;

	mqrm_ptr_table #(
		.NUM_QUEUES(NUM_QUEUES),
		.AW        (QW),
		.DW        (DW)
	) u_ptr_table (
		.clk    (clk),
		.arst_n (arst_n),
		.rd_en  (pt_re),
		.rd_addr(QW'(queue_id)),
		.rd_data(pt_rdata),
		.wr_en  (pt_we),
		.wr_addr(pt_waddr),
		.wr_data(pt_wdata)
	);

	// decide the operation once the pointers of the addressed queue are back
	always_comb begin
		state_d     = state_q;
		res_fire    = 1'b0;
		res_status  = ST_OK;
		res_popped  = '0;
		res_granted = '0;
		res_empty   = 1'b0;
		pt_we       = 1'b0;
		pt_waddr    = qid_q;
		pt_wdata    = pt_rdata;
		st_we       = 1'b0;
		st_re       = 1'b0;
		st_addr     = AW'(qid_q) * DEPTH_A + AW'(tail_c);
		use_set     = 1'b0;
		use_clr     = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (start)
					state_d = S_PTR;
			end
			S_PTR: begin
				state_d  = S_IDLE;
				res_fire = 1'b1;
				unique case (op_q)
					OP_ALLOC: begin
						if (found_q) begin
							use_set     = 1'b1;
							pt_we       = 1'b1;
							pt_waddr    = grant_q;
							pt_wdata    = '0;
							res_granted = QID_W'(grant_q);
							res_empty   = 1'b1;
						end else begin
							res_status = ST_NOFREE;
						end
					end
					OP_FREE: begin
						use_clr   = qv_q;
						res_empty = qv_q ? (cnt_c == '0) : 1'b1;
					end
					OP_INSERT: begin
						if (!qv_q) begin
							res_status = ST_FULL;
							res_empty  = 1'b1;
						end else if (cnt_c == CNT_FULL) begin
							res_status = ST_FULL;
						end else begin
							st_we    = 1'b1;
							pt_we    = 1'b1;
							pt_wdata = {head_c,
								(tail_c == PTR_LAST) ? {PW{1'b0}} : tail_c + 1'b1,
								cnt_c + 1'b1};
						end
					end
					OP_POP: begin
						if (!qv_q || cnt_c == '0) begin
							res_status = ST_EMPTY;
							res_empty  = 1'b1;
						end else begin
							// fetch the head element; the result is issued from S_POP
							st_re    = 1'b1;
							st_addr  = AW'(qid_q) * DEPTH_A + AW'(head_c);
							pt_we    = 1'b1;
							pt_wdata = {(head_c == PTR_LAST) ? {PW{1'b0}} : head_c + 1'b1,
								tail_c, cnt_c - 1'b1};
							res_fire = 1'b0;
							state_d  = S_POP;
						end
					end
					OP_QUERY: begin
						res_empty = qv_q ? (cnt_c == '0) : 1'b1;
					end
					default: begin
						res_status = ST_OK;
					end
				endcase
			end
			S_POP: begin
				state_d    = S_IDLE;
				res_fire   = 1'b1;
				res_popped = pop_ext[VAL_W-1:0];
				res_empty  = pend_empty_q;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			done     <= 1'b0;
			in_use_q <= '0;
		end else begin
			state_q <= state_d;
			done    <= res_fire;
			if (use_set)
				in_use_q[grant_q] <= 1'b1;
			if (use_clr)
				in_use_q[qid_q] <= 1'b0;
		end
	end

	// hold the request and the allocation choice for the decision cycle, and register the result fields
	always_ff @(posedge clk) begin
		if (pt_re) begin
			op_q    <= op;
			qid_q   <= QW'(queue_id);
			qv_q    <= ({4'd0, queue_id} < NQ_LIM);
			val_q   <= val_ext[ELEM_WIDTH-1:0];
			grant_q <= grant_c;
			found_q <= found_c;
		end
		if (st_re)
			pend_empty_q <= (cnt_c == CW'(1));
		if (res_fire) begin
			status        <= res_status;
			popped_value  <= res_popped;
			granted_queue <= res_granted;
			is_empty      <= res_empty;
		end
	end

	always_ff @(posedge clk) begin
		if (st_we)
			store_mem[st_addr] <= val_q;
		if (st_re)
			store_rd_s1 <= store_mem[st_addr];
	end

endmodule

// ===== hw/rtl/mqrm_checker.sv =====
// Port-level checks on the queue manager, bound to the top level.
module mqrm_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          start,
	input logic                          busy,
	input logic                          done,
	input logic [mqrm_pkg::STATUS_W-1:0] status,
	input logic [mqrm_pkg::VAL_W-1:0]    popped_value,
	input logic [mqrm_pkg::QID_W-1:0]    granted_queue,
	input logic                          is_empty
);

	import mqrm_pkg::*;

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted request did not raise busy");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while still busy");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe on two cycles in a row");

	a_nofree_fields: assert property (@(posedge clk) disable iff (!arst_n)
		done && status == ST_NOFREE |-> granted_queue == '0 && !is_empty &&
			popped_value == '0)
		else $error("failed allocate carries nonzero fields");

	a_popped_ok: assert property (@(posedge clk) disable iff (!arst_n)
		done && popped_value != '0 |-> status == ST_OK && granted_queue == '0)
		else $error("popped value with error status or grant");

endmodule

bind multi_queue_ring_manager_unit mqrm_checker u_mqrm_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.done         (done),
	.status       (status),
	.popped_value (popped_value),
	.granted_queue(granted_queue),
	.is_empty     (is_empty)
);
